/* rtl/acst_pkg.sv */
package acst_pkg;

   localparam int TIME_W     = 48;
   localparam int TICKS_LO_W = 16;
   localparam int TICKS_HI_W = 17;
   localparam int TICKS_W    = 32;
   localparam int TICKS_Q_W  = 48;
   localparam int ERR_W      = 48;
   localparam int OFFSET_W   = 64;
   localparam int SLOPE_W    = 40;
   localparam int RATE_W     = 24;
   localparam int WIDE_W     = 52;
   localparam int DIFF_W     = 58;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 208;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_SLOPE_INITIAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_INITIAL  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_LIMIT    = 2'd2;

   localparam logic [SLOPE_W-1:0] SLOPE_INITIAL_RESET = 40'd104857610737;
   localparam logic [RATE_W-1:0]  RATE_INITIAL_RESET  = 24'd8389;
   localparam logic [RATE_W-1:0]  RATE_LIMIT_RESET    = 24'd1509949;
   localparam logic [ERR_W-1:0]   MAG_RESET           = 48'd65536;

   // shared multiplier: 52 x 56 bits, one 8-bit digit of b per cycle
   localparam int MUL_A_W     = 52;
   localparam int MUL_B_W     = 56;
   localparam int MUL_DIGIT_W = 8;
   localparam int MUL_STEPS   = MUL_B_W / MUL_DIGIT_W;
   localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

   // 0.0139694087 in Q0.32
   localparam logic [MUL_B_W-1:0] SLOPE_GAIN = 56'd59998154;
   // floor(2^56 / 10), quotient is product >> 56
   localparam logic [MUL_B_W-1:0] RECIP10    = 56'h19999999999999;

   localparam logic [RATE_W+1:0] RATE_UP   = 26'd367;
   localparam logic [RATE_W+1:0] RATE_DOWN = 26'd215;

   typedef struct packed {
      logic [SLOPE_W-1:0] slope_initial;
      logic [RATE_W-1:0]  rate_initial;
      logic [RATE_W-1:0]  rate_limit;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PROD_GO,
      S_PROD_WAIT,
      S_ERR1,
      S_ERR2,
      S_ERR3,
      S_FIRST,
      S_D_GO,
      S_D_WAIT,
      S_OFS,
      S_DS_GO,
      S_DS_WAIT,
      S_SLOPE,
      S_RATE1,
      S_RATE2,
      S_TDIV_GO,
      S_TDIV_WAIT,
      S_TCOR,
      S_TRND,
      S_MDIV_GO,
      S_MDIV_WAIT,
      S_MCOR,
      S_OUT
   } state_type;

endpackage

/* rtl/acst_mul.sv */
module acst_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  acst_pkg::mul_req_type         mul_req,
   output logic [acst_pkg::MUL_P_W-1:0]  product,
   output logic                          done
);

   logic [acst_pkg::MUL_A_W-1:0]   a_ff, a_in;
   logic [acst_pkg::MUL_B_W-1:0]   b_ff, b_in;
   logic [acst_pkg::MUL_A_W-1:0]   hi_ff, hi_in;
   logic [acst_pkg::MUL_B_W-1:0]   lo_ff, lo_in;
   logic [acst_pkg::MUL_CNT_W-1:0] count_ff, count_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [acst_pkg::MUL_A_W+acst_pkg::MUL_DIGIT_W-1:0] partial;
   logic [acst_pkg::MUL_A_W+acst_pkg::MUL_DIGIT_W-1:0] sum;

   assign partial = a_ff * b_ff[acst_pkg::MUL_DIGIT_W-1:0];
   assign sum     = {{acst_pkg::MUL_DIGIT_W{1'b0}}, hi_ff} + partial;

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (mul_req.start) begin
         a_in     = mul_req.a;
         b_in     = mul_req.b;
         hi_in    = '0;
         lo_in    = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in    = sum[acst_pkg::MUL_A_W+acst_pkg::MUL_DIGIT_W-1:acst_pkg::MUL_DIGIT_W];
         lo_in    = {sum[acst_pkg::MUL_DIGIT_W-1:0],
                     lo_ff[acst_pkg::MUL_B_W-1:acst_pkg::MUL_DIGIT_W]};
         b_in     = b_ff >> acst_pkg::MUL_DIGIT_W;
         count_in = count_ff + 1'b1;
         if (count_ff == acst_pkg::MUL_CNT_W'(acst_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      count_ff <= count_in;
   end

   assign product = {hi_ff, lo_ff};
   assign done    = done_ff;

endmodule

/* rtl/acst_csr.sv */
module acst_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [acst_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [acst_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [acst_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output acst_pkg::cfg_type                cfg
);

   acst_pkg::cfg_type                 cfg_ff, cfg_in;
   logic [acst_pkg::CSR_INDEX_W-1:0]  index;
   logic                              wr;

   assign index = csr_paddr[acst_pkg::CSR_ADDR_W-1:3];
   assign wr    = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (index)
            acst_pkg::REG_SLOPE_INITIAL:
               cfg_in.slope_initial = csr_pwdata[acst_pkg::SLOPE_W-1:0];
            acst_pkg::REG_RATE_INITIAL:
               cfg_in.rate_initial = csr_pwdata[acst_pkg::RATE_W-1:0];
            acst_pkg::REG_RATE_LIMIT:
               cfg_in.rate_limit = csr_pwdata[acst_pkg::RATE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         acst_pkg::REG_SLOPE_INITIAL:
            csr_prdata = acst_pkg::CSR_DATA_W'(cfg_ff.slope_initial);
         acst_pkg::REG_RATE_INITIAL:
            csr_prdata = acst_pkg::CSR_DATA_W'(cfg_ff.rate_initial);
         acst_pkg::REG_RATE_LIMIT:
            csr_prdata = acst_pkg::CSR_DATA_W'(cfg_ff.rate_limit);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slope_initial <= acst_pkg::SLOPE_INITIAL_RESET;
         cfg_ff.rate_initial  <= acst_pkg::RATE_INITIAL_RESET;
         cfg_ff.rate_limit    <= acst_pkg::RATE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

/* rtl/adaptive_clock_offset_slope_tracker_unit.sv */
// Channel  Dir  Fields
// req      in   tdata: local_time_ms[47:0] ticks_low[63:48] ticks_high[80:64]
// rsp      out  tdata: tick_count prediction_error offset_out slope_out rate_out
// csr      in   APB write/read, slope_initial @0x00, rate_initial @0x08, rate_limit @0x10
//
// One transaction at a time. A tracking sample makes five passes through the shared
// 52x56 multiplier (prediction, offset step, slope step and two divides by ten), a first
// sample only the prediction; the next transaction can be accepted in the cycle after the
// result is loaded. req_tready is high only while idle; a held result stalls the next
// result, not acceptance. Synchronous reset clears the offset, the error trend and the
// started flag and sets the error magnitude to its reset value.
module adaptive_clock_offset_slope_tracker_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // local_time_ms[47:0], ticks_low[63:48], ticks_high[80:64], zero pad
   input  logic [acst_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tick_count[31:0], prediction_error[79:32], offset_out[143:80],
   // slope_out[183:144], rate_out[207:184]
   output logic [acst_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [acst_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [acst_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [acst_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   acst_pkg::cfg_type     cfg;
   acst_pkg::mul_req_type mul_req;
   logic [acst_pkg::MUL_P_W-1:0] mul_p;
   logic                         mul_done;

   acst_pkg::state_type state_ff, state_in;

   logic [acst_pkg::TIME_W-1:0]   time_ff, time_in;
   logic [acst_pkg::TICKS_W-1:0]  ticks_ff, ticks_in;
   logic [acst_pkg::SLOPE_W-1:0]  slope_ff, slope_in;
   logic [acst_pkg::RATE_W-1:0]   rate_ff, rate_in;
   logic [acst_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [acst_pkg::ERR_W-1:0]    trend_ff, trend_in;
   logic [acst_pkg::ERR_W-1:0]    mag_ff, mag_in;
   logic                          started_ff, started_in;
   logic [acst_pkg::DIFF_W-1:0]   diff_ff, diff_in;
   logic [acst_pkg::ERR_W-1:0]    err_ff, err_in;
   logic [acst_pkg::ERR_W-1:0]    emag_ff, emag_in;
   logic [acst_pkg::ERR_W-1:0]    d_ff, d_in;
   logic [acst_pkg::WIDE_W-1:0]   tmag10_ff, tmag10_in;
   logic [acst_pkg::WIDE_W-1:0]   xs_ff, xs_in;
   logic [acst_pkg::WIDE_W-1:0]   x_ff, x_in;
   logic                          xneg_ff, xneg_in;
   logic [acst_pkg::WIDE_W-1:0]   q_ff, q_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [acst_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic accept;
   logic rsp_load;
   logic rsp_free;

   // joined ticks
   logic [acst_pkg::TICKS_HI_W-1:0] hi_read;
   logic [acst_pkg::TICKS_LO_W-1:0] lo_read;
   logic [acst_pkg::TICKS_W-1:0]    hi_shift;

   // quotient correction for the divides by ten
   logic [acst_pkg::WIDE_W-1:0] q_raw, q_times10, q_rem, q_fix;

   // datapath temporaries
   logic [acst_pkg::DIFF_W+7:0]     e_wide;
   logic [acst_pkg::OFFSET_W:0]     ofs_sum;
   logic [acst_pkg::ERR_W-1:0]      d_val;
   logic [acst_pkg::DIFF_W-2:0]     ds_val;
   logic [acst_pkg::DIFF_W-1:0]     slope_sum;
   logic [acst_pkg::ERR_W-1:0]      trend_abs;
   logic [acst_pkg::RATE_W+1:0]     rate_next;

   acst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   acst_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .product (mul_p),
      .done    (mul_done)
   );

   assign accept   = req_tvalid & req_tready;
   assign rsp_free = ~rsp_tvalid_ff | rsp_tready;

   assign lo_read = req_tdata[63:48];
   assign hi_read = req_tdata[80:64];

   always_comb begin
      hi_shift = {hi_read, 15'b0};
      if (hi_shift[15] ^ lo_read[15]) begin
         hi_shift = hi_shift - 32'h8000;
      end
   end

   assign q_raw     = mul_p[acst_pkg::MUL_P_W-1:acst_pkg::MUL_B_W];
   assign q_times10 = (q_raw << 3) + (q_raw << 1);
   assign q_rem     = x_ff - q_times10;
   assign q_fix     = (q_rem >= acst_pkg::WIDE_W'(10)) ? q_raw + 1'b1 : q_raw;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         acst_pkg::S_IDLE:      if (req_tvalid) state_in = acst_pkg::S_PROD_GO;
         acst_pkg::S_PROD_GO:   state_in = acst_pkg::S_PROD_WAIT;
         acst_pkg::S_PROD_WAIT: if (mul_done) state_in = acst_pkg::S_ERR1;
         acst_pkg::S_ERR1:      state_in = acst_pkg::S_ERR2;
         acst_pkg::S_ERR2:      state_in = acst_pkg::S_ERR3;
         acst_pkg::S_ERR3:      state_in = started_ff ? acst_pkg::S_D_GO : acst_pkg::S_FIRST;
         acst_pkg::S_FIRST:     state_in = acst_pkg::S_OUT;
         acst_pkg::S_D_GO:      state_in = acst_pkg::S_D_WAIT;
         acst_pkg::S_D_WAIT:    if (mul_done) state_in = acst_pkg::S_OFS;
         acst_pkg::S_OFS:       state_in = acst_pkg::S_DS_GO;
         acst_pkg::S_DS_GO:     state_in = acst_pkg::S_DS_WAIT;
         acst_pkg::S_DS_WAIT:   if (mul_done) state_in = acst_pkg::S_SLOPE;
         acst_pkg::S_SLOPE:     state_in = acst_pkg::S_RATE1;
         acst_pkg::S_RATE1:     state_in = acst_pkg::S_RATE2;
         acst_pkg::S_RATE2:     state_in = acst_pkg::S_TDIV_GO;
         acst_pkg::S_TDIV_GO:   state_in = acst_pkg::S_TDIV_WAIT;
         acst_pkg::S_TDIV_WAIT: if (mul_done) state_in = acst_pkg::S_TCOR;
         acst_pkg::S_TCOR:      state_in = acst_pkg::S_TRND;
         acst_pkg::S_TRND:      state_in = acst_pkg::S_MDIV_GO;
         acst_pkg::S_MDIV_GO:   state_in = acst_pkg::S_MDIV_WAIT;
         acst_pkg::S_MDIV_WAIT: if (mul_done) state_in = acst_pkg::S_MCOR;
         acst_pkg::S_MCOR:      state_in = acst_pkg::S_OUT;
         acst_pkg::S_OUT:       if (rsp_free) state_in = acst_pkg::S_IDLE;
         default:               state_in = acst_pkg::S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready    = 1'b0;
      rsp_load      = 1'b0;
      mul_req.start = 1'b0;
      mul_req.a     = x_ff;
      mul_req.b     = acst_pkg::RECIP10;
      case (state_ff)
         acst_pkg::S_IDLE: req_tready = 1'b1;
         acst_pkg::S_PROD_GO: begin
            mul_req.start = 1'b1;
            mul_req.a     = acst_pkg::MUL_A_W'(time_ff);
            mul_req.b     = acst_pkg::MUL_B_W'(slope_ff);
         end
         acst_pkg::S_D_GO: begin
            mul_req.start = 1'b1;
            mul_req.a     = acst_pkg::MUL_A_W'(emag_ff);
            mul_req.b     = acst_pkg::MUL_B_W'(rate_ff);
         end
         acst_pkg::S_DS_GO: begin
            mul_req.start = 1'b1;
            mul_req.a     = acst_pkg::MUL_A_W'(d_ff);
            mul_req.b     = acst_pkg::SLOPE_GAIN;
         end
         acst_pkg::S_TDIV_GO: mul_req.start = 1'b1;
         acst_pkg::S_MDIV_GO: mul_req.start = 1'b1;
         acst_pkg::S_OUT:     rsp_load = rsp_free;
         default: req_tready = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      time_in    = time_ff;
      ticks_in   = ticks_ff;
      slope_in   = slope_ff;
      rate_in    = rate_ff;
      offset_in  = offset_ff;
      trend_in   = trend_ff;
      mag_in     = mag_ff;
      started_in = started_ff;
      diff_in    = diff_ff;
      err_in     = err_ff;
      emag_in    = emag_ff;
      d_in       = d_ff;
      tmag10_in  = tmag10_ff;
      xs_in      = xs_ff;
      x_in       = x_ff;
      xneg_in    = xneg_ff;
      q_in       = q_ff;
      e_wide     = '0;
      ofs_sum    = '0;
      d_val      = mul_p[71:24];
      ds_val     = mul_p[72:16];
      slope_sum  = '0;
      trend_abs  = '0;
      rate_next  = '0;
      case (state_ff)
         acst_pkg::S_IDLE: begin
            if (accept) begin
               time_in  = req_tdata[acst_pkg::TIME_W-1:0];
               ticks_in = {hi_shift[31:16], lo_read};
               if (!started_ff) begin
                  slope_in = cfg.slope_initial;
                  rate_in  = cfg.rate_initial;
               end
            end
         end
         acst_pkg::S_ERR1: begin
            diff_in = {10'b0, ticks_ff, 16'b0} - {2'b0, mul_p[87:32]};
         end
         acst_pkg::S_ERR2: begin
            e_wide = {{8{diff_ff[acst_pkg::DIFF_W-1]}}, diff_ff}
                   - {{2{offset_ff[acst_pkg::OFFSET_W-1]}}, offset_ff};
            if (e_wide[acst_pkg::DIFF_W+7] &&
                  (e_wide[acst_pkg::DIFF_W+7:acst_pkg::ERR_W-1] != '1)) begin
               err_in = {1'b1, {(acst_pkg::ERR_W-1){1'b0}}};
            end else if (!e_wide[acst_pkg::DIFF_W+7] &&
                  (e_wide[acst_pkg::DIFF_W+7:acst_pkg::ERR_W-1] != '0)) begin
               err_in = {1'b0, {(acst_pkg::ERR_W-1){1'b1}}};
            end else begin
               err_in = e_wide[acst_pkg::ERR_W-1:0];
            end
         end
         acst_pkg::S_ERR3: begin
            emag_in = err_ff[acst_pkg::ERR_W-1] ? (~err_ff + 1'b1) : err_ff;
         end
         acst_pkg::S_FIRST: begin
            offset_in  = {{(acst_pkg::OFFSET_W-acst_pkg::DIFF_W){diff_ff[acst_pkg::DIFF_W-1]}},
                          diff_ff};
            started_in = 1'b1;
         end
         acst_pkg::S_OFS: begin
            d_in = d_val;
            if (err_ff[acst_pkg::ERR_W-1]) begin
               ofs_sum = {offset_ff[acst_pkg::OFFSET_W-1], offset_ff}
                       - {17'b0, d_val};
            end else begin
               ofs_sum = {offset_ff[acst_pkg::OFFSET_W-1], offset_ff}
                       + {17'b0, d_val};
            end
            if (ofs_sum[acst_pkg::OFFSET_W] != ofs_sum[acst_pkg::OFFSET_W-1]) begin
               offset_in = {ofs_sum[acst_pkg::OFFSET_W],
                            {(acst_pkg::OFFSET_W-1){~ofs_sum[acst_pkg::OFFSET_W]}}};
            end else begin
               offset_in = ofs_sum[acst_pkg::OFFSET_W-1:0];
            end
         end
         acst_pkg::S_SLOPE: begin
            if (err_ff[acst_pkg::ERR_W-1]) begin
               if ({17'b0, slope_ff} > ds_val) begin
                  slope_in = slope_ff - ds_val[acst_pkg::SLOPE_W-1:0];
               end else begin
                  slope_in = '0;
               end
            end else begin
               slope_sum = {18'b0, slope_ff} + {1'b0, ds_val};
               if (slope_sum[acst_pkg::DIFF_W-1:acst_pkg::SLOPE_W] != '0) begin
                  slope_in = '1;
               end else begin
                  slope_in = slope_sum[acst_pkg::SLOPE_W-1:0];
               end
            end
         end
         acst_pkg::S_RATE1: begin
            trend_abs = trend_ff[acst_pkg::ERR_W-1] ? (~trend_ff + 1'b1) : trend_ff;
            tmag10_in = ({4'b0, trend_abs} << 3) + ({4'b0, trend_abs} << 1);
            xs_in     = ({{4{trend_ff[acst_pkg::ERR_W-1]}}, trend_ff} << 3)
                      + {{4{trend_ff[acst_pkg::ERR_W-1]}}, trend_ff}
                      + {{4{err_ff[acst_pkg::ERR_W-1]}}, err_ff};
         end
         acst_pkg::S_RATE2: begin
            rate_next = {2'b0, rate_ff};
            if (mag_ff != '0) begin
               if (tmag10_ff > {4'b0, mag_ff}) begin
                  rate_next = rate_next + acst_pkg::RATE_UP;
               end else begin
                  rate_next = rate_next - acst_pkg::RATE_DOWN;
               end
            end
            if (!rate_next[acst_pkg::RATE_W+1] &&
                  (rate_next[acst_pkg::RATE_W:0] > {1'b0, cfg.rate_limit})) begin
               rate_next = {2'b0, cfg.rate_limit};
            end
            if (rate_next[acst_pkg::RATE_W+1]) begin
               rate_next = ~rate_next + 1'b1;
            end
            rate_in = rate_next[acst_pkg::RATE_W-1:0];
            xneg_in = xs_ff[acst_pkg::WIDE_W-1];
            x_in    = xs_ff[acst_pkg::WIDE_W-1] ? (~xs_ff + 1'b1) : xs_ff;
         end
         acst_pkg::S_TCOR: q_in = q_fix;
         acst_pkg::S_TRND: begin
            trend_in = xneg_ff ? (~q_ff[acst_pkg::ERR_W-1:0] + 1'b1)
                               : q_ff[acst_pkg::ERR_W-1:0];
            x_in     = ({4'b0, mag_ff} << 3) + {4'b0, mag_ff} + {4'b0, emag_ff};
         end
         acst_pkg::S_MCOR: mag_in = q_fix[acst_pkg::ERR_W-1:0];
         default: time_in = time_ff;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {rate_ff, slope_ff, offset_ff, err_ff, ticks_ff};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= acst_pkg::S_IDLE;
         started_ff    <= 1'b0;
         offset_ff     <= '0;
         trend_ff      <= '0;
         mag_ff        <= acst_pkg::MAG_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         offset_ff     <= offset_in;
         trend_ff      <= trend_in;
         mag_ff        <= mag_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      time_ff      <= time_in;
      ticks_ff     <= ticks_in;
      slope_ff     <= slope_in;
      rate_ff      <= rate_in;
      diff_ff      <= diff_in;
      err_ff       <= err_in;
      emag_ff      <= emag_in;
      d_ff         <= d_in;
      tmag10_ff    <= tmag10_in;
      xs_ff        <= xs_in;
      x_ff         <= x_in;
      xneg_ff      <= xneg_in;
      q_ff         <= q_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

/* sim/acst_tracking_checker.sv */
module acst_tracking_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [acst_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [acst_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [acst_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [acst_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   input  logic                                csr_pready,
   output int                                  mismatches,
   output int                                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ERR_MAX_V = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ERR_MIN_V = -ERR_MAX_V - 1;
   localparam logic signed [65:0] OFS_MAX_V = 66'sh0_7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [65:0] OFS_MIN_V = -OFS_MAX_V - 1;

   typedef struct packed {
      logic [acst_pkg::RATE_W-1:0]   rate_out;
      logic [acst_pkg::SLOPE_W-1:0]  slope_out;
      logic [acst_pkg::OFFSET_W-1:0] offset_out;
      logic [acst_pkg::ERR_W-1:0]    prediction_error;
      logic [acst_pkg::TICKS_W-1:0]  tick_count;
   } sample_estimate_type;

   sample_estimate_type estimates_due[$];

   logic [acst_pkg::SLOPE_W-1:0]         cfg_slope_initial;
   logic [acst_pkg::RATE_W-1:0]          cfg_rate_initial;
   logic [acst_pkg::RATE_W-1:0]          cfg_rate_limit;
   logic [acst_pkg::SLOPE_W-1:0]         slope_est;
   logic signed [acst_pkg::OFFSET_W-1:0] offset_est;
   logic [acst_pkg::RATE_W-1:0]          adapt_rate;
   longint                               error_trend;
   logic [63:0]                          error_mag;
   bit                                   started;

   task automatic track_sample(input logic [acst_pkg::REQ_DATA_W-1:0] item,
                               output sample_estimate_type est);
      logic [acst_pkg::TIME_W-1:0]     t;
      logic [acst_pkg::TICKS_LO_W-1:0] lo16;
      logic [acst_pkg::TICKS_W-1:0]    hi;
      logic [acst_pkg::TICKS_W-1:0]    ticks;
      logic [87:0]           prod_full;
      logic signed [65:0]    tick_q;
      logic signed [65:0]    prod;
      logic signed [65:0]    diff;
      logic signed [65:0]    ofs;
      logic [71:0]           step_full;
      logic [95:0]           gain_full;
      logic [63:0]           emag;
      logic [63:0]           step;
      logic [63:0]           slope_step;
      logic [64:0]           slope_sum;
      logic signed [31:0]    rate;
      longint                err;
      longint                tmag;
      t = item[47:0];
      lo16 = item[63:48];
      hi = {item[80:64], 15'b0};
      if (hi[15] ^ lo16[15]) hi = hi - 32'h8000;
      hi[15:0] = 16'h0;
      ticks = hi + {16'h0, lo16};
      tick_q = $signed({18'b0, ticks, 16'b0});
      if (!started) begin
         slope_est = cfg_slope_initial;
         adapt_rate = cfg_rate_initial;
      end
      prod_full = t * slope_est;
      prod = $signed({10'b0, prod_full[87:32]});
      ofs = offset_est;
      diff = tick_q - prod - ofs;
      if (diff > ERR_MAX_V) err = ERR_MAX_V;
      else if (diff < ERR_MIN_V) err = ERR_MIN_V;
      else err = longint'(diff);
      emag = (err < 0) ? -err : err;
      if (!started) begin
         offset_est = acst_pkg::OFFSET_W'(tick_q - prod);
         started = 1'b1;
      end else begin
         step_full = emag * adapt_rate;
         step = 64'(step_full >> 24);
         gain_full = step * acst_pkg::SLOPE_GAIN;
         slope_step = 64'(gain_full >> 16);
         if (err < 0) begin
            ofs = ofs - $signed({2'b00, step});
            slope_est = (slope_est > slope_step) ?
                        acst_pkg::SLOPE_W'(slope_est - slope_step) : '0;
         end else begin
            ofs = ofs + $signed({2'b00, step});
            slope_sum = slope_est + slope_step;
            slope_est = (slope_sum > 65'hFF_FFFF_FFFF) ? '1 : slope_sum[39:0];
         end
         if (ofs > OFS_MAX_V) ofs = OFS_MAX_V;
         else if (ofs < OFS_MIN_V) ofs = OFS_MIN_V;
         offset_est = acst_pkg::OFFSET_W'(ofs);
         tmag = (error_trend < 0) ? -error_trend : error_trend;
         rate = {8'b0, adapt_rate};
         if (error_mag != 0) begin
            if (tmag * 10 > error_mag) rate = rate + int'(acst_pkg::RATE_UP);
            else rate = rate - int'(acst_pkg::RATE_DOWN);
         end
         if (rate > int'(cfg_rate_limit)) rate = int'(cfg_rate_limit);
         if (rate < 0) rate = -rate;
         adapt_rate = rate[acst_pkg::RATE_W-1:0];
         error_trend = (error_trend * 9 + err) / 10;
         error_mag = (error_mag * 9 + emag) / 10;
      end
      est.tick_count = ticks;
      est.prediction_error = err[47:0];
      est.offset_out = offset_est;
      est.slope_out = slope_est;
      est.rate_out = adapt_rate;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      sample_estimate_type est;
      if (reset) begin
         cfg_slope_initial = acst_pkg::SLOPE_INITIAL_RESET;
         cfg_rate_initial = acst_pkg::RATE_INITIAL_RESET;
         cfg_rate_limit = acst_pkg::RATE_LIMIT_RESET;
         slope_est = acst_pkg::SLOPE_INITIAL_RESET;
         offset_est = '0;
         adapt_rate = acst_pkg::RATE_INITIAL_RESET;
         error_trend = 0;
         error_mag = 64'(acst_pkg::MAG_RESET);
         started = 1'b0;
         mismatches = 0;
         estimates_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[acst_pkg::CSR_ADDR_W-1:3])
               acst_pkg::REG_SLOPE_INITIAL:
                  cfg_slope_initial = csr_pwdata[acst_pkg::SLOPE_W-1:0];
               acst_pkg::REG_RATE_INITIAL:
                  cfg_rate_initial = csr_pwdata[acst_pkg::RATE_W-1:0];
               acst_pkg::REG_RATE_LIMIT:
                  cfg_rate_limit = csr_pwdata[acst_pkg::RATE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (estimates_due.size() == 0) begin
               $display("%0t unexpected transaction expected none got %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               est = estimates_due.pop_front();
               check_field("tick_count", est.tick_count, rsp_tdata[31:0]);
               check_field("prediction_error", est.prediction_error, rsp_tdata[79:32]);
               check_field("offset_out", est.offset_out, rsp_tdata[143:80]);
               check_field("slope_out", est.slope_out, rsp_tdata[183:144]);
               check_field("rate_out", est.rate_out, rsp_tdata[207:184]);
            end
         end
         if (req_tvalid && req_tready) begin
            track_sample(req_tdata, est);
            estimates_due.push_back(est);
         end
      end
      outstanding = estimates_due.size();
   end

endmodule

/* sim/adaptive_clock_offset_slope_tracker_unit_test.sv */
module adaptive_clock_offset_slope_tracker_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 250;
   localparam int PHASES      = 6;
   localparam logic [acst_pkg::CSR_ADDR_W-1:0] ADDR_SLOPE_INITIAL =
      {acst_pkg::REG_SLOPE_INITIAL, 3'b000};
   localparam logic [acst_pkg::CSR_ADDR_W-1:0] ADDR_RATE_INITIAL =
      {acst_pkg::REG_RATE_INITIAL, 3'b000};
   localparam logic [acst_pkg::CSR_ADDR_W-1:0] ADDR_RATE_LIMIT =
      {acst_pkg::REG_RATE_LIMIT, 3'b000};
   localparam logic [acst_pkg::CSR_ADDR_W-1:0] ADDR_UNMAPPED = 5'h18;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // local_time_ms[47:0], ticks_low[63:48], ticks_high[80:64], zero pad
   logic [acst_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // tick_count[31:0], prediction_error[79:32], offset_out[143:80],
   // slope_out[183:144], rate_out[207:184]
   logic [acst_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [acst_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [acst_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [acst_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   int idle_pct = 35;
   int cycles = 0;
   int mismatches;
   int outstanding;

   adaptive_clock_offset_slope_tracker_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   acst_tracking_checker tracking_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("adaptive_clock_offset_slope_tracker_unit: mismatch");
         $finish;
      end
   end

   task automatic csr_write(input logic [acst_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [acst_pkg::CSR_DATA_W-1:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic send_item(input logic [acst_pkg::REQ_DATA_W-1:0] item);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_tdata = item;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // high word is read skew ticks after the low word
   task automatic send_reading(input logic [acst_pkg::TIME_W-1:0] t,
                               input logic [31:0] ticks, input int skew);
      logic [31:0] late;
      late = ticks + skew;
      send_item({7'b0, late[31:15], ticks[15:0], t});
   endtask

   task automatic run_track(input int count);
      logic [acst_pkg::TIME_W-1:0] t0;
      logic [31:0]       base;
      logic [63:0]       elapsed;
      int                rate_q8;
      int                skew;
      t0 = {12'b0, 4'($urandom), 32'($urandom)};
      base = $urandom;
      rate_q8 = $urandom_range(6200, 6400);
      elapsed = 0;
      repeat (count) begin
         skew = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(1);
         send_reading(t0 + elapsed[47:0],
                      base + 32'((elapsed * rate_q8) >> 24) + $urandom_range(2), skew);
         elapsed += $urandom_range(1, 1 << 20);
      end
   endtask

   task automatic run_phase(input int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(99) < 15) begin
            send_item({7'b0, 17'($urandom), 16'($urandom), 16'($urandom), 32'($urandom)});
            sent++;
         end else begin
            len = $urandom_range(10, 60);
            if (len > items - sent) len = items - sent;
            run_track(len);
            sent += len;
         end
      end
   endtask

   task automatic drain();
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      logic [acst_pkg::RATE_W-1:0] limit;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      csr_write(ADDR_SLOPE_INITIAL,
                64'(acst_pkg::SLOPE_INITIAL_RESET) + $urandom_range(1 << 20));
      csr_write(ADDR_RATE_INITIAL, 64'($urandom_range(2000, 40000)));
      csr_write(ADDR_RATE_LIMIT, 64'(acst_pkg::RATE_LIMIT_RESET));
      csr_write(ADDR_UNMAPPED, '1);

      // first sample seeds the offset
      send_reading(48'd1000 << 16, 32'd24414, 0);
      send_reading(48'd1001 << 16, 32'd24438, 0);
      // high word read across a bit-15 boundary, both directions
      send_reading(48'd1002 << 16, 32'h0001_7FF0, 32'h20);
      send_reading(48'd1003 << 16, 32'h0001_FFF0, 32'h20);
      // wrap through 2^32
      send_reading(48'd0, 32'hFFFF_FFFF, 1);
      send_reading(48'd0, 32'd0, 0);
      send_reading('1, 32'hFFFF_FFFF, 0);
      send_reading('1, 32'd0, 0);
      send_item({7'b0, 17'h1FFFF, 16'h0000, 48'h0});
      send_item({7'b0, 17'h0AAAA, 16'h5555, 48'hAAAA_AAAA_AAAA});
      send_item({7'b0, 17'h15555, 16'hAAAA, 48'h5555_5555_5555});
      send_reading(48'd2000 << 16, 32'd48828, 0);
      send_reading(48'd2001 << 16, 32'd48852, 1);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         idle_pct = (p == 2) ? 0 : 35;
         case (p)
            0: limit = '1;
            1: limit = '0;
            2: limit = acst_pkg::RATE_LIMIT_RESET;
            3: limit = 24'd1;
            4: limit = 24'($urandom_range(400, 60000));
            default: limit = 24'($urandom);
         endcase
         csr_write(ADDR_SLOPE_INITIAL, (p % 2) ? {$urandom, $urandom} : 64'd0);
         csr_write(ADDR_RATE_INITIAL, (p % 2) ? 64'd0 : {$urandom, $urandom});
         csr_write(ADDR_RATE_LIMIT, {$urandom, 8'($urandom), limit});
         run_phase(PHASE_ITEMS);
         drain();
      end

      idle_pct = 35;
      drain();
      repeat (64) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("adaptive_clock_offset_slope_tracker_unit: match");
      end else begin
         $display("adaptive_clock_offset_slope_tracker_unit: mismatch");
      end
      $finish;
   end

endmodule
